// ===== sv/tcw_pkg.sv =====
// Shared constants, types and helpers for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  // cells that move up by one row during a scroll
  localparam int MOVE_CELLS = CELLS - COLUMNS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 4;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  localparam logic [CLR_W-1:0] FG_RESET = 4'h7;
  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL_PRIME,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  function automatic logic [CELL_W-1:0] blank_cell(input logic [CLR_W-1:0] bg);
    blank_cell = {bg, bg, CH_SPACE};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// Top level of the text console writer: cursor control and screen store sequencer.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------------
//  command   | start / busy              | opcode, char_code, read_row, read_col
//  result    | done (one-cycle strobe)   | cursor_col_out, cursor_row_out, scrolled,
//            |                           | cell_value
//  config    | write_enable              | reg_index, write_data
//
// A put without scroll, or an unused opcode, reports in the cycle after acceptance and
// keeps busy low. A read passes through ST_READ for the registered store read. Clear
// and a scrolling put sweep the store, both with one store write per cycle.
// Reset resets the cursor and colours; the store holds no reset value and is not swept.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   opcode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tcw_pkg::ROW_W-1:0]    read_row,
  input  wire logic [tcw_pkg::COL_W-1:0]    read_col,
  input  wire logic                         write_enable,
  input  wire logic                         reg_index,
  input  wire logic [tcw_pkg::CLR_W-1:0]    write_data,
  output logic                              done,
  output logic      [tcw_pkg::COL_W-1:0]    cursor_col_out,
  output logic      [tcw_pkg::ROW_W-1:0]    cursor_row_out,
  output logic                              scrolled,
  output logic      [tcw_pkg::CELL_W-1:0]   cell_value
);

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::COL_W-1:0]  cursor_col, cursor_col_next;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [tcw_pkg::CLR_W-1:0]  fg_color, bg_color;
  logic [tcw_pkg::ADDR_W-1:0] cnt;
  logic                       read_ok;

  logic                        done_next, scrolled_next, scroll_need;
  logic [tcw_pkg::CELL_W-1:0]  cell_next;

  logic                        ram_we;
  logic [tcw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

  logic                        accept, printable, read_in_range, last_cell;
  logic [tcw_pkg::ROW_W:0]     row_adv;
  logic [tcw_pkg::COL_W:0]     col_inc;
  logic [tcw_pkg::ADDR_W:0]    src_addr;
  tcw_pkg::op_t                op;

  assign op        = tcw_pkg::op_t'(opcode);
  assign accept    = start && !busy;
  assign busy      = (state != tcw_pkg::ST_IDLE);
  assign printable = !char_code[tcw_pkg::CHAR_W-1] && (char_code >= tcw_pkg::CH_SPACE);
  assign read_in_range = (32'(read_row) < tcw_pkg::ROWS) && (32'(read_col) < tcw_pkg::COLUMNS);
  assign last_cell = (32'(cnt) == tcw_pkg::CELLS - 1);
  assign src_addr  = (tcw_pkg::ADDR_W+1)'(cnt) + (tcw_pkg::ADDR_W+1)'(tcw_pkg::COLUMNS + 1);

  // cursor movement for a put
  always_comb begin
    col_inc = (tcw_pkg::COL_W+1)'(cursor_col) + 1'b1;
    row_adv = (tcw_pkg::ROW_W+1)'(cursor_row);
    cursor_col_next = cursor_col;
    if (char_code == tcw_pkg::CH_CR) begin
      cursor_col_next = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      cursor_col_next = '0;
      row_adv = row_adv + 1'b1;
    end else if (32'(col_inc) >= tcw_pkg::COLUMNS) begin
      cursor_col_next = '0;
      row_adv = row_adv + 1'b1;
    end else begin
      cursor_col_next = col_inc[tcw_pkg::COL_W-1:0];
    end
    scroll_need = (32'(row_adv) >= tcw_pkg::ROWS);
    cursor_row_next = scroll_need ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                  : row_adv[tcw_pkg::ROW_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tcw_pkg::OP_PUT:   state_next = scroll_need ? tcw_pkg::ST_SCROLL_PRIME
                                                        : tcw_pkg::ST_IDLE;
            tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::OP_READ:  state_next = tcw_pkg::ST_READ;
            default:           state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ:         state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_SCROLL_PRIME: state_next = tcw_pkg::ST_SCROLL;
      tcw_pkg::ST_SCROLL:       state_next = last_cell ? tcw_pkg::ST_IDLE : tcw_pkg::ST_SCROLL;
      tcw_pkg::ST_CLEAR:        state_next = last_cell ? tcw_pkg::ST_IDLE : tcw_pkg::ST_CLEAR;
      default:                  state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // store accesses and result values
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = cnt;
    ram_wdata     = tcw_pkg::blank_cell(bg_color);
    ram_raddr     = '0;
    done_next     = 1'b0;
    scrolled_next = 1'b0;
    cell_next     = '0;
    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tcw_pkg::OP_PUT: begin
              ram_we    = printable;
              ram_waddr = tcw_pkg::cell_addr(cursor_row, cursor_col);
              ram_wdata = {bg_color, fg_color, char_code};
              done_next = !scroll_need;
            end
            tcw_pkg::OP_READ: begin
              if (read_in_range) begin
                ram_raddr = tcw_pkg::cell_addr(read_row, read_col);
              end
            end
            tcw_pkg::OP_CLEAR: ;
            default: done_next = 1'b1;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        done_next = 1'b1;
        cell_next = read_ok ? ram_rdata : '0;
      end
      tcw_pkg::ST_SCROLL_PRIME: begin
        ram_raddr = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
      end
      tcw_pkg::ST_SCROLL: begin
        // write cell cnt from the row below, then blank the bottom row
        ram_we = 1'b1;
        if (32'(cnt) < tcw_pkg::MOVE_CELLS) begin
          ram_wdata = ram_rdata;
        end
        if (32'(cnt) < tcw_pkg::MOVE_CELLS - 1) begin
          ram_raddr = src_addr[tcw_pkg::ADDR_W-1:0];
        end
        done_next     = last_cell;
        scrolled_next = last_cell;
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        done_next = last_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      fg_color   <= tcw_pkg::FG_RESET;
      bg_color   <= tcw_pkg::BG_RESET;
      done       <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (accept && op == tcw_pkg::OP_PUT) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
      if (write_enable) begin
        if (reg_index == tcw_pkg::REG_FG) begin
          fg_color <= write_data;
        end else begin
          bg_color <= write_data;
        end
      end
      // advance the sweep pointer, drop it back to zero otherwise
      if (state == tcw_pkg::ST_SCROLL || state == tcw_pkg::ST_CLEAR) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scrolled   <= scrolled_next;
    cell_value <= cell_next;
    if (accept) begin
      read_ok <= read_in_range;
    end
  end

  assign cursor_col_out = cursor_col;
  assign cursor_row_out = cursor_row;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 opcode,
  input wire logic                       done,
  input wire logic [tcw_pkg::COL_W-1:0]  cursor_col_out,
  input wire logic [tcw_pkg::ROW_W-1:0]  cursor_row_out,
  input wire logic                       scrolled
);

  // an unused opcode is answered in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == tcw_pkg::OP_NOP) |=> done)
    else $error("unused opcode transaction not answered in the next cycle");

  // a read holds busy in its read state, then reports
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == tcw_pkg::OP_READ) |=> (busy && !done) ##1 done)
    else $error("read transaction timing wrong");

  // a clear sweeps the store, so busy follows at once
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == tcw_pkg::OP_CLEAR) |=> (busy && !done))
    else $error("clear transaction did not raise busy");

  assert property (@(posedge clk) disable iff (rst)
    scrolled |-> done)
    else $error("scrolled shown outside a result");

  assert property (@(posedge clk) disable iff (rst)
    (32'(cursor_col_out) < tcw_pkg::COLUMNS) && (32'(cursor_row_out) < tcw_pkg::ROWS))
    else $error("cursor out of range");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .opcode         (opcode),
  .done           (done),
  .cursor_col_out (cursor_col_out),
  .cursor_row_out (cursor_row_out),
  .scrolled       (scrolled)
);

`default_nettype wire

// ===== tb/tb_text_console_writer_unit.sv =====
// Self-checking testbench for the text console writer: scripted and random commands.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;

  localparam int RANDOM_CMDS = 950;
  // every command a full scroll plus the longest sender gap, taken several times over
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    tcw_pkg::op_t               op;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::ROW_W-1:0]  row;
    logic [tcw_pkg::COL_W-1:0]  col;
  } command_t;

  typedef struct packed {
    logic [tcw_pkg::COL_W-1:0]  col;
    logic [tcw_pkg::ROW_W-1:0]  row;
    logic                       scrolled;
    logic [tcw_pkg::CELL_W-1:0] cell_val;
  } report_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  opcode = tcw_pkg::OP_NOP;
  logic [tcw_pkg::CHAR_W-1:0]  char_code = '0;
  logic [tcw_pkg::ROW_W-1:0]   read_row = '0;
  logic [tcw_pkg::COL_W-1:0]   read_col = '0;
  logic                        write_enable = 1'b0;
  logic                        reg_index = tcw_pkg::REG_FG;
  logic [tcw_pkg::CLR_W-1:0]   write_data = '0;
  logic                        done;
  logic [tcw_pkg::COL_W-1:0]   cursor_col_out;
  logic [tcw_pkg::ROW_W-1:0]   cursor_row_out;
  logic                        scrolled;
  logic [tcw_pkg::CELL_W-1:0]  cell_value;

  text_console_writer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .write_enable   (write_enable),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .done           (done),
    .cursor_col_out (cursor_col_out),
    .cursor_row_out (cursor_row_out),
    .scrolled       (scrolled),
    .cell_value     (cell_value)
  );

  always #5 clk = ~clk;

  // console image kept alongside the block
  logic [tcw_pkg::CELL_W-1:0] screen_image [tcw_pkg::CELLS];
  int                         cur_col = 0;
  int                         cur_row = 0;
  logic [tcw_pkg::CLR_W-1:0]  fg_reg = tcw_pkg::FG_RESET;
  logic [tcw_pkg::CLR_W-1:0]  bg_reg = tcw_pkg::BG_RESET;

  command_t          pending_cmds [$];
  report_t           awaited_reports [$];
  int                sender_idle_pct = 0;
  int                gap_left = 0;
  int                mismatches = 0;
  int unsigned       cycle_cnt = 0;

  function automatic report_t execute_command(command_t c);
    report_t r;
    int i;
    r = '0;
    case (c.op)
      tcw_pkg::OP_PUT: begin
        if (c.ch >= tcw_pkg::CH_SPACE && c.ch <= 8'h7F)
          screen_image[cur_row * tcw_pkg::COLUMNS + cur_col] = {bg_reg, fg_reg, c.ch};
        if (c.ch == tcw_pkg::CH_CR) begin
          cur_col = 0;
        end else if (c.ch == tcw_pkg::CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else begin
          cur_col++;
          if (cur_col >= tcw_pkg::COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= tcw_pkg::ROWS) begin
          for (i = 0; i < tcw_pkg::MOVE_CELLS; i++)
            screen_image[i] = screen_image[i + tcw_pkg::COLUMNS];
          for (i = tcw_pkg::MOVE_CELLS; i < tcw_pkg::CELLS; i++)
            screen_image[i] = {bg_reg, bg_reg, tcw_pkg::CH_SPACE};
          cur_row = tcw_pkg::ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < tcw_pkg::CELLS; i++)
          screen_image[i] = {bg_reg, bg_reg, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::OP_READ: begin
        if (c.row < tcw_pkg::ROWS && c.col < tcw_pkg::COLUMNS)
          r.cell_val = screen_image[int'(c.row) * tcw_pkg::COLUMNS + int'(c.col)];
      end
      default: ;
    endcase
    r.col = tcw_pkg::COL_W'(cur_col);
    r.row = tcw_pkg::ROW_W'(cur_row);
    return r;
  endfunction

  function automatic command_t cmd_of(tcw_pkg::op_t op, logic [tcw_pkg::CHAR_W-1:0] ch,
                                      logic [tcw_pkg::ROW_W-1:0] row,
                                      logic [tcw_pkg::COL_W-1:0] col);
    command_t c;
    c.op  = op;
    c.ch  = ch;
    c.row = row;
    c.col = col;
    return c;
  endfunction

  // reads only ever reach cells that a clear has already written
  function automatic command_t random_command(int lf_pct);
    command_t c;
    int r;
    int pick;
    c.ch  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    c.row = tcw_pkg::ROW_W'($urandom_range(0, 31));
    c.col = tcw_pkg::COL_W'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 73) begin
      c.op = tcw_pkg::OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < lf_pct)
        c.ch = tcw_pkg::CH_LF;
      else if (pick < lf_pct + 4)
        c.ch = tcw_pkg::CH_CR;
      else if (pick < lf_pct + 14)
        c.ch = tcw_pkg::CHAR_W'($urandom_range(0, 31));
      else if (pick < lf_pct + 24)
        c.ch = tcw_pkg::CHAR_W'($urandom_range(128, 255));
      else
        c.ch = tcw_pkg::CHAR_W'($urandom_range(32, 127));
    end else if (r < 76) begin
      c.op = tcw_pkg::OP_CLEAR;
    end else if (r < 98) begin
      c.op = tcw_pkg::OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        c.row = tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS, 31));
      end else if (pick < 10) begin
        c.row = tcw_pkg::ROW_W'($urandom_range(0, 31));
        c.col = tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS, 127));
      end else begin
        c.row = (pick < 50) ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                            : tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1));
        c.col = tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
      end
    end else begin
      c.op = tcw_pkg::OP_NOP;
    end
    return c;
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 99) >= sender_idle_pct)
      return 0;
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic flag_mismatch(string what, report_t want, report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t %s: expected col %0d row %0d scrolled %0d cell %h",
             $realtime, what, want.col, want.row, want.scrolled, want.cell_val);
      $display(", got col %0d row %0d scrolled %0d cell %h",
               got.col, got.row, got.scrolled, got.cell_val);
    end
  endtask

  // driver: hold a command until it is taken, then send the next after its gap
  always @(posedge clk) begin : driver
    command_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        awaited_reports.push_back(execute_command(
          cmd_of(tcw_pkg::op_t'(opcode), char_code, read_row, read_col)));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          opcode    <= nxt.op;
          char_code <= nxt.ch;
          read_row  <= nxt.row;
          read_col  <= nxt.col;
          start     <= 1'b1;
          gap_left  = draw_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    report_t got;
    report_t want;
    if (!rst && done) begin
      got = {cursor_col_out, cursor_row_out, scrolled, cell_value};
      if (awaited_reports.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, got);
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_text_console_writer_unit: FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || awaited_reports.size() != 0 || busy)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [tcw_pkg::CLR_W-1:0] val);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= val;
    @(posedge clk);
    if (idx == tcw_pkg::REG_FG)
      fg_reg = val;
    else
      bg_reg = val;
  endtask

  initial begin : stimulus
    int issued;
    int phase;
    int n;
    int lf_pct;
    int k;
    logic [tcw_pkg::CLR_W-1:0] fg_new;
    logic [tcw_pkg::CLR_W-1:0] bg_new;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // scripted part on the reset colours; nothing in range is read before the clear
    sender_idle_pct = 30;
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h41, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 5'd31, 7'd127));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h7F, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h1F, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h80, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h00, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'd31, 7'd127));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'(tcw_pkg::COLUMNS)));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'(tcw_pkg::ROWS), 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_NOP, 8'hFF, 5'd31, 7'd127));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'(tcw_pkg::ROWS - 1),
                                  7'(tcw_pkg::COLUMNS - 1)));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_PUT, 8'h7E, 5'd0, 7'd0));
    pending_cmds.push_back(cmd_of(tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0));
    wait_idle();

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_CMDS) begin
      // colour extremes first, then random settings
      case (phase)
        0: begin fg_new = 4'h0; bg_new = 4'hF; end
        1: begin fg_new = 4'hF; bg_new = 4'h0; end
        2: begin fg_new = 4'hF; bg_new = 4'hF; end
        3: begin fg_new = 4'h0; bg_new = 4'h0; end
        default: begin
          fg_new = tcw_pkg::CLR_W'($urandom_range(0, 15));
          bg_new = tcw_pkg::CLR_W'($urandom_range(0, 15));
        end
      endcase
      if (phase < 4 || $urandom_range(0, 2) != 0) begin
        program_reg(tcw_pkg::REG_FG, fg_new);
        program_reg(tcw_pkg::REG_BG, bg_new);
      end else if ($urandom_range(0, 1) != 0) begin
        program_reg(tcw_pkg::REG_BG, bg_new);
      end else begin
        program_reg(tcw_pkg::REG_FG, fg_new);
      end
      write_enable <= 1'b0;

      // newline-heavy phases walk the cursor down and keep the store scrolling
      lf_pct = (phase == 0 || $urandom_range(0, 2) == 0) ? 25 : 3;
      case ($urandom_range(0, 2))
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 20;
        default: sender_idle_pct = 50;
      endcase
      n = $urandom_range(50, 110);
      if (n > RANDOM_CMDS - issued)
        n = RANDOM_CMDS - issued;
      for (k = 0; k < n; k++)
        pending_cmds.push_back(random_command(lf_pct));
      issued += n;
      phase++;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb_text_console_writer_unit: PASS");
    else
      $display("tb_text_console_writer_unit: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
tb/tb_text_console_writer_unit.sv
